FILE: src/shamh_pkg.sv
`default_nettype none
package shamh_pkg;

  localparam int unsigned Rounds = 64;
  localparam int unsigned RndW = $clog2(Rounds);
  localparam int unsigned BlockBits = 512;

  // round constants
  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value
  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // commands from the byte packer to the compression engine
  typedef struct packed {
    logic start;
    logic reinit;
  } core_ctl_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

FILE: src/sha256_message_hasher_unit.sv
`default_nettype none
// SHA-256 hasher taking one message byte per beat. Bytes are packed into a
// 512-bit block at one per cycle; a full block runs through one shared round
// unit at one round per cycle, followed by the final chaining add, during
// which in_stall_o is high, so a byte that completes a block holds off the
// next byte until the compression ends. The beat that ends a message
// (last_byte_i) starts padding: pad bytes are added one per cycle up to the
// length field, then one or two compressions follow (two when 56 or more
// bytes sit in the block), then eight digest beats H0..H7 on the output
// channel. No input is taken until the eighth digest beat leaves.
// A beat with no_byte_i set and last_byte_i clear has no effect; with both set
// it ends the message without a byte, which also hashes the empty message.
module sha256_message_hasher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        no_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             final_word_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  logic        ending_q, ending_d;
  logic        mark_q, mark_d;
  logic        len_done_q, len_done_d;
  logic [2:0]  idx_q, idx_d;
  logic [shamh_pkg::BlockBits-1:0] blk_q, blk_d;
  logic        blk_en;
  shamh_pkg::core_ctl_t ctl;
  logic        core_done;
  logic [7:0][31:0] hash;
  logic        in_acc, out_acc;

  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign out_acc = (state_q == S_OUT) && !out_stall_i;

  // byte packing, padding and message sequencing
  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    len_d = len_q;
    ending_d = ending_q;
    mark_d = mark_q;
    len_done_d = len_done_q;
    idx_d = idx_q;
    blk_d = blk_q;
    blk_en = 1'b0;
    ctl = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ending_d = last_byte_i;
          mark_d = 1'b0;
          len_done_d = 1'b0;
          if (!no_byte_i) begin
            blk_en = 1'b1;
            blk_d = {blk_q[shamh_pkg::BlockBits-9:0], data_byte_i};
            fill_d = fill_q + 1'b1;
            len_d = len_q + 1'b1;
            if (fill_q == 6'd63) begin
              ctl.start = 1'b1;
              state_d = S_COMP;
            end else if (last_byte_i) begin
              state_d = S_PAD;
            end
          end else if (last_byte_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        blk_en = 1'b1;
        if (!mark_q) begin
          mark_d = 1'b1;
          blk_d = {blk_q[shamh_pkg::BlockBits-9:0], shamh_pkg::PadMark};
          fill_d = fill_q + 1'b1;
          if (fill_q == 6'd63) begin
            ctl.start = 1'b1;
            state_d = S_COMP;
          end
        end else if (fill_q == shamh_pkg::LenPos) begin
          // 64-bit bit length closes the block
          blk_d = {blk_q[shamh_pkg::BlockBits-65:0], len_q, 3'b000};
          fill_d = '0;
          len_done_d = 1'b1;
          ctl.start = 1'b1;
          state_d = S_COMP;
        end else begin
          blk_d = {blk_q[shamh_pkg::BlockBits-9:0], 8'h00};
          fill_d = fill_q + 1'b1;
          if (fill_q == 6'd63) begin
            ctl.start = 1'b1;
            state_d = S_COMP;
          end
        end
      end
      S_COMP: begin
        if (core_done) begin
          if (!ending_q) begin
            state_d = S_IDLE;
          end else if (len_done_q) begin
            idx_d = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 3'd7) begin
            ctl.reinit = 1'b1;
            fill_d = '0;
            len_d = '0;
            ending_d = 1'b0;
            mark_d = 1'b0;
            len_done_d = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      len_q <= '0;
      ending_q <= 1'b0;
      mark_q <= 1'b0;
      len_done_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      len_q <= len_d;
      ending_q <= ending_d;
      mark_q <= mark_d;
      len_done_q <= len_done_d;
      idx_q <= idx_d;
    end
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (blk_en) blk_q <= blk_d;
  end

  // the core loads the block including the byte that completes it
  shamh_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .block_i (blk_d),
    .done_o  (core_done),
    .hash_o  (hash)
  );

  // ports
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign digest_word_o = hash[idx_q];
  assign word_index_o = idx_q;
  assign final_word_o = (idx_q == 3'd7);

endmodule
`default_nettype wire

FILE: src/shamh_core.sv
`default_nettype none
module shamh_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire shamh_pkg::core_ctl_t               ctl_i,
  input  wire logic [shamh_pkg::BlockBits-1:0]    block_i,
  output logic                                    done_o,
  output logic [7:0][31:0]                        hash_o
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_e;

  core_state_e state_q, state_d;
  logic [shamh_pkg::RndW-1:0] rnd_q, rnd_d;
  logic [31:0] hash_q [8];
  logic [31:0] work_q [8];
  logic [31:0] win_q [16];
  logic [31:0] t1, t2, w_new;

  // one round of the compression and one step of the schedule
  always_comb begin
    t1 = work_q[7] + shamh_pkg::bsig1(work_q[4])
         + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
         + shamh_pkg::RoundK[rnd_q] + win_q[0];
    t2 = shamh_pkg::bsig0(work_q[0])
         + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
    w_new = win_q[0] + shamh_pkg::ssig0(win_q[1]) + win_q[9] + shamh_pkg::ssig1(win_q[14]);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    case (state_q)
      C_IDLE: begin
        if (ctl_i.start) begin
          state_d = C_ROUND;
          rnd_d = '0;
        end
      end
      C_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == shamh_pkg::RndW'(shamh_pkg::Rounds - 1)) begin
          state_d = C_ADD;
        end
      end
      C_ADD: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q <= '0;
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
    end
  end

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= shamh_pkg::InitHash[i];
    end else if (ctl_i.reinit) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= shamh_pkg::InitHash[i];
    end else if (state_q == C_ADD) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && ctl_i.start) begin
      for (int i = 0; i < 8; i++) work_q[i] <= hash_q[i];
      for (int i = 0; i < 16; i++) begin
        win_q[i] <= block_i[shamh_pkg::BlockBits-1-32*i -: 32];
      end
    end else if (state_q == C_ROUND) begin
      work_q[0] <= t1 + t2;
      work_q[1] <= work_q[0];
      work_q[2] <= work_q[1];
      work_q[3] <= work_q[2];
      work_q[4] <= work_q[3] + t1;
      work_q[5] <= work_q[4];
      work_q[6] <= work_q[5];
      work_q[7] <= work_q[6];
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_new;
    end
  end

  assign done_o = (state_q == C_ADD);

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[i] = hash_q[i];
  end

endmodule
`default_nettype wire
